### sv/wsfd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

    localparam int LENGTH_WIDTH = 64;
    localparam int CFG_WIDTH = 32;
    localparam int CMP_WIDTH = (LENGTH_WIDTH > CFG_WIDTH) ? LENGTH_WIDTH : CFG_WIDTH;

    localparam logic [CFG_WIDTH-1:0] MAX_PAYLOAD_RESET = 32'd16777216;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_KEY_BYTES = 4'd4;
    localparam logic [3:0] CONTROL_OPCODE_MIN = 4'h8;

    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_HALT    = 6'b100000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [3:0]  message_opcode;
        logic        end_of_message;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

endpackage

`default_nettype wire

### sv/wsfd_parser.sv
// Frame parser: input byte register, header state machine and payload unmasking.
`default_nettype none

module wsfd_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [31:0]           cfg_wr_data,
    input  wire logic                  in_accept,
    input  wire logic [7:0]            rx_byte,
    output logic                       pipe_valid,
    output wsfd_pkg::push_t            push
);

    localparam int LW = wsfd_pkg::LENGTH_WIDTH;

    wsfd_pkg::phase_t  phase_reg, phase_next;
    logic              final_reg, final_next;
    logic              masked_reg, masked_next;
    logic              first_reg, first_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic [3:0]        hbl_reg, hbl_next;
    logic [LW-1:0]     rem_reg, rem_next;
    logic [31:0]       key_reg, key_next;
    logic [1:0]        idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic [31:0]       max_reg;
    logic              pipe_valid_reg;
    logic [7:0]        byte_reg;

    logic              do_finish;
    logic              do_begin;
    logic [LW-1:0]     fin_len;
    logic              fin_ovf;
    logic              fin_masked;
    logic [LW-1:0]     begin_len;
    logic [3:0]        hbl_dec;
    logic [LW-1:0]     ext_len;
    logic [7:0]        key_byte;
    logic              too_large;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= wsfd_pkg::PH_HDR0;
            final_reg      <= 1'b0;
            masked_reg     <= 1'b0;
            first_reg      <= 1'b1;
            opcode_reg     <= 4'd0;
            hbl_reg        <= 4'd0;
            rem_reg        <= '0;
            key_reg        <= 32'd0;
            idx_reg        <= 2'd0;
            ovf_reg        <= 1'b0;
            max_reg        <= wsfd_pkg::MAX_PAYLOAD_RESET;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            final_reg      <= final_next;
            masked_reg     <= masked_next;
            first_reg      <= first_next;
            opcode_reg     <= opcode_next;
            hbl_reg        <= hbl_next;
            rem_reg        <= rem_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            ovf_reg        <= ovf_next;
            pipe_valid_reg <= in_accept;
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign hbl_dec = hbl_reg - 4'd1;
    assign ext_len = {rem_reg[LW-9:0], byte_reg};

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        final_next  = final_reg;
        masked_next = masked_reg;
        first_next  = first_reg;
        opcode_next = opcode_reg;
        hbl_next    = hbl_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        ovf_next    = ovf_reg;
        push        = '0;
        push.res.message_opcode = opcode_reg;
        do_finish   = 1'b0;
        do_begin    = 1'b0;
        fin_len     = '0;
        fin_ovf     = 1'b0;
        fin_masked  = masked_reg;
        begin_len   = rem_reg;
        too_large   = 1'b0;

        if (pipe_valid_reg)
        begin
            unique case (phase_reg)
                wsfd_pkg::PH_HDR0:
                begin
                    final_next = byte_reg[7] ||
                                 (byte_reg[3:0] >= wsfd_pkg::CONTROL_OPCODE_MIN);
                    if (first_reg)
                    begin
                        opcode_next = byte_reg[3:0];
                        first_next  = 1'b0;
                    end
                    phase_next = wsfd_pkg::PH_HDR1;
                end
                wsfd_pkg::PH_HDR1:
                begin
                    masked_next = byte_reg[7];
                    ovf_next    = 1'b0;
                    if (byte_reg[6:0] == wsfd_pkg::LEN_EXT16 ||
                        byte_reg[6:0] == wsfd_pkg::LEN_EXT64)
                    begin
                        hbl_next   = (byte_reg[6:0] == wsfd_pkg::LEN_EXT16) ?
                                     wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                        rem_next   = '0;
                        phase_next = wsfd_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        do_finish  = 1'b1;
                        fin_len    = LW'(byte_reg[6:0]);
                        fin_masked = byte_reg[7];
                    end
                end
                wsfd_pkg::PH_EXTLEN:
                begin
                    ovf_next = ovf_reg || (rem_reg[LW-1 -: 8] != 8'd0);
                    rem_next = ext_len;
                    hbl_next = hbl_dec;
                    if (hbl_dec == 4'd0)
                    begin
                        do_finish = 1'b1;
                        fin_len   = ext_len;
                        fin_ovf   = ovf_next;
                    end
                end
                wsfd_pkg::PH_MASK:
                begin
                    key_next = {key_reg[23:0], byte_reg};
                    hbl_next = hbl_dec;
                    if (hbl_dec == 4'd0)
                    begin
                        do_begin  = 1'b1;
                        begin_len = rem_reg;
                    end
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    idx_next = idx_reg + 2'd1;
                    rem_next = rem_reg - LW'(1);
                    push.valid              = 1'b1;
                    push.res.kind           = wsfd_pkg::KIND_DATA;
                    push.res.data_byte      = masked_reg ? (byte_reg ^ key_byte) : byte_reg;
                    push.res.end_of_message = (rem_reg == LW'(1)) && final_reg;
                    if (rem_reg == LW'(1))
                    begin
                        phase_next = wsfd_pkg::PH_HDR0;
                        if (final_reg)
                        begin
                            first_next = 1'b1;
                        end
                    end
                end
                wsfd_pkg::PH_HALT:
                begin
                    phase_next = wsfd_pkg::PH_HALT;
                end
                default:
                begin
                    phase_next = wsfd_pkg::PH_HALT;
                end
            endcase
        end

        if (do_finish)
        begin
            too_large = fin_ovf ||
                        (wsfd_pkg::CMP_WIDTH'(fin_len) > wsfd_pkg::CMP_WIDTH'(max_reg));
            if (too_large)
            begin
                phase_next              = wsfd_pkg::PH_HALT;
                push.valid              = 1'b1;
                push.res.kind           = wsfd_pkg::KIND_ERR;
                push.res.end_of_message = 1'b1;
            end
            else
            begin
                rem_next = fin_len;
                if (fin_masked)
                begin
                    key_next   = 32'd0;
                    hbl_next   = wsfd_pkg::MASK_KEY_BYTES;
                    phase_next = wsfd_pkg::PH_MASK;
                end
                else
                begin
                    do_begin  = 1'b1;
                    begin_len = fin_len;
                end
            end
        end

        if (do_begin)
        begin
            idx_next = 2'd0;
            if (begin_len != '0)
            begin
                phase_next = wsfd_pkg::PH_PAYLOAD;
            end
            else
            begin
                phase_next = wsfd_pkg::PH_HDR0;
                if (final_reg)
                begin
                    push.valid              = 1'b1;
                    push.res.kind           = wsfd_pkg::KIND_END;
                    push.res.end_of_message = 1'b1;
                    first_next              = 1'b1;
                end
            end
        end
    end

    assign pipe_valid = pipe_valid_reg;

    // Once halted, the parser stays halted until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfd_pkg::PH_HALT |=> phase_reg == wsfd_pkg::PH_HALT)
        else $error("parser left the halted phase");

    // An error result always halts the parser.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.res.kind == wsfd_pkg::KIND_ERR |=> phase_reg == wsfd_pkg::PH_HALT)
        else $error("error result without halt");

    // Payload results come only from the payload phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.res.kind == wsfd_pkg::KIND_DATA |->
            phase_reg == wsfd_pkg::PH_PAYLOAD && pipe_valid_reg)
        else $error("payload result outside the payload phase");

endmodule

`default_nettype wire

### sv/wsfd_out_queue.sv
// Result queue between the parser and the output channel.
`default_nettype none

module wsfd_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wsfd_pkg::push_t   push,
    input  wire logic              pop,
    output wsfd_pkg::result_t      head,
    output logic                   not_empty,
    output logic [wsfd_pkg::QCNT_W-1:0] count
);

    localparam logic [wsfd_pkg::QPTR_W-1:0] LAST_PTR = wsfd_pkg::QPTR_W'(wsfd_pkg::QUEUE_DEPTH - 1);

    wsfd_pkg::result_t             entry_reg [wsfd_pkg::QUEUE_DEPTH];
    logic [wsfd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [wsfd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [wsfd_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.res;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wsfd_pkg::QCNT_W'(wsfd_pkg::QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    // A push into a full queue must coincide with a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && count_reg == wsfd_pkg::QCNT_W'(wsfd_pkg::QUEUE_DEPTH) |-> do_pop)
        else $error("result queue overflow");

endmodule

`default_nettype wire

### sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
// An accepted byte is registered, then its result is written to the result queue.
// Throughput: one byte per clock cycle, sustained while results are taken.
// A three-entry result queue decouples the output; input ready depends on registers only.
// Reset is asynchronous and active low; it returns the parser to the first header byte.
// Reset also restores the maximum frame payload register to 16 MiB.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [3:0]       message_opcode,
    output logic             end_of_message
);

    wsfd_pkg::push_t                 push;
    wsfd_pkg::result_t               head;
    logic                            pipe_valid;
    logic [wsfd_pkg::QCNT_W-1:0]     count;
    logic [wsfd_pkg::QCNT_W:0]       occupancy;
    logic                            in_accept;

    // Requests in flight plus queued results must leave room for one more.
    assign occupancy = {1'b0, count} + {{wsfd_pkg::QCNT_W{1'b0}}, pipe_valid};
    assign in_ready  = occupancy < (wsfd_pkg::QCNT_W + 1)'(wsfd_pkg::QUEUE_DEPTH);
    assign in_accept = in_valid && in_ready;

    wsfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .rx_byte     (rx_byte),
        .pipe_valid  (pipe_valid),
        .push        (push)
    );

    wsfd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_ready),
        .head      (head),
        .not_empty (out_valid),
        .count     (count)
    );

    assign kind           = head.kind;
    assign data_byte      = head.data_byte;
    assign message_opcode = head.message_opcode;
    assign end_of_message = head.end_of_message;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the WebSocket frame deframer: random frame streams against a predictor.
`timescale 1ns / 100ps

module testbench;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  message_opcode;
    logic        end_of_message;

    websocket_frame_deframer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .message_opcode (message_opcode),
        .end_of_message (end_of_message)
    );

    logic [7:0]          rx_backlog[$];
    wsfd_pkg::result_t   due_results[$];

    // Parser state as the block should hold it.
    logic [31:0]      frame_limit = wsfd_pkg::MAX_PAYLOAD_RESET;
    wsfd_pkg::phase_t parse_at = wsfd_pkg::PH_HDR0;
    logic        frame_final = 1'b0;
    logic        frame_masked = 1'b0;
    logic        message_fresh = 1'b1;
    logic [3:0]  message_op = '0;
    logic [3:0]  header_left = '0;
    logic [63:0] payload_left = '0;
    logic [31:0] mask_word = '0;
    logic [1:0]  mask_pos = '0;
    logic        halted = 1'b0;
    logic        length_wide = 1'b0;

    int  fail_count = 0;
    int  bytes_queued = 0;
    int  bytes_taken = 0;
    int  results_seen = 0;
    int  markers_seen = 0;
    int  errors_seen = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap(inout bit calm);
        int r;
        if ($urandom_range(0, 79) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic post_result(input wsfd_pkg::kind_t k, input logic [7:0] d, input logic last);
        wsfd_pkg::result_t r;
        r.kind = k;
        r.data_byte = d;
        r.message_opcode = message_op;
        r.end_of_message = last;
        due_results.push_back(r);
    endtask

    task automatic open_payload();
        mask_pos = '0;
        if (payload_left != 0)
            parse_at = wsfd_pkg::PH_PAYLOAD;
        else
        begin
            parse_at = wsfd_pkg::PH_HDR0;
            if (frame_final)
            begin
                post_result(wsfd_pkg::KIND_END, 8'h00, 1'b1);
                message_fresh = 1'b1;
            end
        end
    endtask

    task automatic close_length(input logic [63:0] len);
        if (length_wide || len > {32'd0, frame_limit})
        begin
            halted = 1'b1;
            parse_at = wsfd_pkg::PH_HALT;
            post_result(wsfd_pkg::KIND_ERR, 8'h00, 1'b1);
        end
        else
        begin
            payload_left = len;
            if (frame_masked)
            begin
                mask_word = '0;
                header_left = wsfd_pkg::MASK_KEY_BYTES;
                parse_at = wsfd_pkg::PH_MASK;
            end
            else
                open_payload();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [6:0] len7;
        logic [7:0] d;
        int         sel;
        if (!halted)
        begin
            case (parse_at)
                wsfd_pkg::PH_HDR0:
                begin
                    frame_final = b[7] || (b[3:0] >= wsfd_pkg::CONTROL_OPCODE_MIN);
                    if (message_fresh)
                    begin
                        message_op = b[3:0];
                        message_fresh = 1'b0;
                    end
                    parse_at = wsfd_pkg::PH_HDR1;
                end
                wsfd_pkg::PH_HDR1:
                begin
                    len7 = b[6:0];
                    frame_masked = b[7];
                    length_wide = 1'b0;
                    if (len7 == wsfd_pkg::LEN_EXT16 || len7 == wsfd_pkg::LEN_EXT64)
                    begin
                        header_left = (len7 == wsfd_pkg::LEN_EXT16) ?
                                      wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                        payload_left = '0;
                        parse_at = wsfd_pkg::PH_EXTLEN;
                    end
                    else
                        close_length(64'(len7));
                end
                wsfd_pkg::PH_EXTLEN:
                begin
                    if ((payload_left >> (wsfd_pkg::LENGTH_WIDTH - 8)) != 0)
                        length_wide = 1'b1;
                    payload_left = {payload_left[55:0], b};
                    header_left = header_left - 4'd1;
                    if (header_left == 0)
                        close_length(payload_left);
                end
                wsfd_pkg::PH_MASK:
                begin
                    mask_word = {mask_word[23:0], b};
                    header_left = header_left - 4'd1;
                    if (header_left == 0)
                        open_payload();
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    d = b;
                    sel = 3 - int'(mask_pos);
                    if (frame_masked)
                        d = d ^ mask_word[8*sel +: 8];
                    mask_pos = mask_pos + 2'd1;
                    payload_left = payload_left - 64'd1;
                    post_result(wsfd_pkg::KIND_DATA, d, payload_left == 0 && frame_final);
                    if (payload_left == 0)
                    begin
                        parse_at = wsfd_pkg::PH_HDR0;
                        if (frame_final)
                            message_fresh = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Each request carries one received byte; its results are predicted as it is taken.
    always @(posedge clk)
    begin
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
            send_gap = 0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_byte = rx_byte;
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte);
                bytes_taken++;
                nxt_valid = 1'b0;
                send_gap = pick_gap(send_calm);
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (rx_backlog.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_byte = rx_backlog.pop_front();
                end
            end
            in_valid <= nxt_valid;
            rx_byte <= nxt_byte;
        end
    end

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        wsfd_pkg::result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (kind == wsfd_pkg::KIND_END)
                    markers_seen++;
                if (kind == wsfd_pkg::KIND_ERR)
                    errors_seen++;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got kind %0d data %0d",
                             $time, kind, data_byte);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
                    check_field("message_opcode", 32'(want.message_opcode),
                                32'(message_opcode));
                    check_field("end_of_message", 32'(want.end_of_message),
                                32'(end_of_message));
                end
                recv_gap = pick_gap(recv_calm);
            end
            else if (!out_valid && !recv_calm && recv_gap == 0 && $urandom_range(0, 15) == 0)
                recv_gap = $urandom_range(1, 4);
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    function automatic int pick_len(input longint cap);
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 15)
            len = 0;
        else if (r < 80)
            len = $urandom_range(1, 6);
        else if (r < 92)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(21, 130);
        if (cap <= 130 && $urandom_range(0, 9) == 0)
            len = int'(cap);
        if (len > cap)
            len = int'(cap);
        return len;
    endfunction

    task automatic add_frame(input logic fin, input logic [3:0] op, input int len);
        logic        masked;
        logic [31:0] key;
        logic [63:0] len64;
        int          form;
        int          r;
        masked = $urandom_range(0, 9) < 7;
        key = $urandom;
        len64 = 64'(len);
        r = $urandom_range(0, 99);
        if (len > 125)
            form = $urandom_range(1, 2);
        else
            form = (r < 70) ? 0 : (r < 90) ? 1 : 2;
        push_byte({fin, 3'($urandom), op});
        if (form == 0)
            push_byte({masked, len64[6:0]});
        else if (form == 1)
        begin
            push_byte({masked, wsfd_pkg::LEN_EXT16});
            push_byte(len64[15:8]);
            push_byte(len64[7:0]);
        end
        else
        begin
            push_byte({masked, wsfd_pkg::LEN_EXT64});
            for (int k = 7; k >= 0; k--)
                push_byte(len64[8*k +: 8]);
        end
        if (masked)
            for (int k = 3; k >= 0; k--)
                push_byte(key[8*k +: 8]);
        for (int k = 0; k < len; k++)
            push_byte(8'($urandom));
    endtask

    task automatic add_messages(input longint cap, input int count);
        int         stop_at;
        int         frags;
        bit         noisy;
        logic [3:0] first_op;
        logic [3:0] op;
        stop_at = bytes_queued + count;
        while (bytes_queued < stop_at)
        begin
            frags = $urandom_range(1, 4);
            noisy = $urandom_range(0, 9) == 0;
            first_op = noisy ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 2));
            for (int i = 0; i < frags; i++)
            begin
                if (i > 0 && $urandom_range(0, 6) == 0)
                    add_frame(1'($urandom_range(0, 1)), 4'($urandom_range(8, 15)),
                              pick_len(cap < 5 ? cap : 5));
                if (i == 0)
                    op = first_op;
                else
                    op = noisy ? 4'($urandom_range(0, 15)) : 4'h0;
                add_frame(i == frags - 1, op, pick_len(cap));
            end
        end
    endtask

    task automatic set_limit(input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        frame_limit = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge clk);
        while ((rx_backlog.size() != 0 || in_valid || due_results.size() != 0) &&
               waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        if (due_results.size() != 0)
        begin
            fail_count++;
            $display("%0t: expected %0d more results, got none", $time, due_results.size());
            due_results.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Fragmented binary message closed by a masked control frame, then an
        // unmasked text frame with a 64-bit length and reserved bits set.
        rx_backlog = {rx_backlog, 8'h02, 8'h82, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h5A,
                      8'h00, 8'h00,
                      8'h8A, 8'h81, 8'h01, 8'h02, 8'h03, 8'h04, 8'h11,
                      8'hF1, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h01, 8'hFF};
        bytes_queued += 28;
        add_messages(wsfd_pkg::MAX_PAYLOAD_RESET, 250);
        wait_drained();

        set_limit(32'd0);
        add_messages(0, 60);
        wait_drained();

        set_limit(32'($urandom_range(3, 12)));
        add_messages(frame_limit, 250);
        wait_drained();

        set_limit(32'($urandom_range(100, 1000)));
        add_messages(frame_limit, 150);
        wait_drained();

        set_limit(32'hFFFF_FFFF);
        add_messages(32'hFFFF_FFFF, 300);
        // A masked frame one byte beyond the largest limit; everything after it is ignored.
        rx_backlog = {rx_backlog, 8'h82, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                      8'h00, 8'h00};
        bytes_queued += 10;
        for (int k = 0; k < 14; k++)
            push_byte(8'($urandom));
        wait_drained();

        $display("Streamed %0d bytes under five payload limits, including zero and the maximum.",
                 bytes_taken);
        $display("Checked %0d results: %0d end markers and %0d oversize errors.",
                 results_seen, markers_seen, errors_seen);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
